// ===== rtl/vct_pkg.sv =====
// shared types, widths and codes for the virtual channel table
package vct_pkg;

  localparam int NUM_SLOTS_DEF = 1024;

  localparam int OP_W     = 2;
  localparam int NODE_W   = 8;
  localparam int KIND_W   = 8;
  localparam int SLOT_W   = 10;
  localparam int TAG_W    = 28;
  localparam int SEQ_W    = 4;
  localparam int TAGH_W   = TAG_W - SEQ_W;
  localparam int USED_W   = 11;
  localparam int PCT_W    = 7;
  localparam int PERCENT  = 100;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_SEND  = 2'd2,
    OP_RECV  = 2'd3
  } vct_op_t;

  typedef struct packed {
    vct_op_t             op;
    logic [NODE_W-1:0]   peer;
    logic [KIND_W-1:0]   chan_kind;
    logic [SLOT_W-1:0]   slot;
  } vct_in_t;

  typedef struct packed {
    logic                ok;
    logic [SLOT_W-1:0]   handle;
    logic [TAG_W-1:0]    tag;
    logic [NODE_W-1:0]   peer_out;
    logic [USED_W-1:0]   used_count;
    logic [PCT_W-1:0]    used_percent;
  } vct_out_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_CHECK = 4'b1000
  } vct_state_t;

  typedef struct packed {
    logic clr;
    logic take;
    logic step;
    logic commit;
  } vct_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic reject;
    logic used_bit;
    logic out_free;
  } vct_stat_t;

endpackage

// ===== rtl/vct_ram.sv =====
// generic simple dual port ram with registered read
module vct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/vct_ctrl.sv =====
// sequencing state machine for the virtual channel table
module vct_ctrl import vct_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  vct_stat_t stat,
  output vct_cmd_t  cmd
);

  vct_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // occupied slot during a scan: probe the next one
        if (stat.is_alloc && !stat.reject && stat.used_bit) begin
          cmd.step  = 1'b1;
          state_nxt = S_READ;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/vct_dp.sv =====
// slot storage, counters, tag building and result register
module vct_dp import vct_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vct_in_t           in_item,
  input  logic              cfg_valid,
  input  logic [NODE_W-1:0] cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output vct_out_t          out_item,
  input  vct_cmd_t          cmd,
  output vct_stat_t         stat
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int RW = IW + 1;
  localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam int KW = (CW > USED_W) ? CW : USED_W;
  localparam int PQ = PERCENT / NUM_SLOTS;
  localparam int PR = PERCENT % NUM_SLOTS;
  localparam int DW = NODE_W + TAGH_W + 2 * SEQ_W;

  vct_in_t           item_r;
  logic [IW-1:0]     pos_r, pos_nxt, pos_inc, start_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     rem_r, rem_nxt;
  logic [PCT_W-1:0]  pct_r, pct_nxt;
  logic [NODE_W-1:0] own_r;
  logic              out_valid_r;
  vct_out_t          out_r, res;

  logic              is_alloc, full, oor, reject, ok;
  logic [XW-1:0]     in_slot_x, pos_x;
  logic [KW-1:0]     count_x;
  logic [NODE_W-1:0] hi_node, lo_node;
  logic [TAGH_W-1:0] new_tagh;

  logic              used_we, used_wd, used_q;
  logic              data_we;
  logic [DW-1:0]     data_wd, data_q;
  logic [NODE_W-1:0] peer_q;
  logic [TAGH_W-1:0] tagh_q;
  logic [SEQ_W-1:0]  send_q, recv_q;

  logic [RW-1:0]     sum_up, rem_up, rem_dn;
  logic              wrap_up, wrap_dn;
  logic [PCT_W-1:0]  pct_up, pct_dn;

  // per-slot storage
  vct_ram #(.WIDTH(1), .DEPTH(NUM_SLOTS)) u_used (
    .clk   (clk),
    .we    (used_we),
    .waddr (pos_r),
    .wdata (used_wd),
    .raddr (pos_r),
    .rdata (used_q)
  );

  vct_ram #(.WIDTH(DW), .DEPTH(NUM_SLOTS)) u_data (
    .clk   (clk),
    .we    (data_we),
    .waddr (pos_r),
    .wdata (data_wd),
    .raddr (pos_r),
    .rdata (data_q)
  );

  assign peer_q = data_q[DW-1 -: NODE_W];
  assign tagh_q = data_q[2*SEQ_W +: TAGH_W];
  assign send_q = data_q[SEQ_W +: SEQ_W];
  assign recv_q = data_q[0 +: SEQ_W];

  assign is_alloc  = (item_r.op == OP_ALLOC);
  assign full      = (count_r == CW'(NUM_SLOTS));
  assign oor       = (32'(item_r.slot) >= 32'(NUM_SLOTS));
  assign reject    = is_alloc ? full : oor;
  assign ok        = !reject && (is_alloc ? !used_q : used_q);
  assign in_slot_x = XW'(in_item.slot);
  assign pos_x     = XW'(pos_r);
  assign pos_inc   = (pos_r == IW'(NUM_SLOTS - 1)) ? '0 : pos_r + 1'b1;

  assign stat.clr_last = (pos_r == IW'(NUM_SLOTS - 1));
  assign stat.is_alloc = is_alloc;
  assign stat.reject   = reject;
  assign stat.used_bit = used_q;
  assign stat.out_free = !out_valid_r || out_ready;

  // larger node first in the tag
  assign hi_node  = (item_r.peer > own_r) ? item_r.peer : own_r;
  assign lo_node  = (item_r.peer > own_r) ? own_r : item_r.peer;
  assign new_tagh = {hi_node, lo_node, item_r.chan_kind};

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.clr || cmd.step) begin
      pos_nxt = pos_inc;
    end else if (cmd.take) begin
      pos_nxt = (in_item.op == OP_ALLOC) ? start_r : in_slot_x[IW-1:0];
    end
  end

  always_comb begin
    used_we = cmd.clr || (cmd.commit && ok && (is_alloc || item_r.op == OP_FREE));
    used_wd = !cmd.clr && is_alloc;
    data_we = cmd.commit && ok && (item_r.op != OP_FREE);
    case (item_r.op)
      OP_ALLOC: data_wd = {item_r.peer, new_tagh, {SEQ_W{1'b0}}, {SEQ_W{1'b0}}};
      OP_SEND:  data_wd = {peer_q, tagh_q, send_q + 1'b1, recv_q};
      OP_RECV:  data_wd = {peer_q, tagh_q, send_q, recv_q + 1'b1};
      default:  data_wd = data_q;
    endcase
  end

  // usage percent kept as quotient and remainder of count * 100 / slots
  always_comb begin
    sum_up  = {1'b0, rem_r} + RW'(PR);
    wrap_up = (sum_up >= RW'(NUM_SLOTS));
    rem_up  = wrap_up ? sum_up - RW'(NUM_SLOTS) : sum_up;
    pct_up  = pct_r + PCT_W'(PQ) + PCT_W'(wrap_up);
    wrap_dn = ({1'b0, rem_r} < RW'(PR));
    rem_dn  = wrap_dn ? {1'b0, rem_r} + RW'(NUM_SLOTS) - RW'(PR)
                      : {1'b0, rem_r} - RW'(PR);
    pct_dn  = pct_r - PCT_W'(PQ) - PCT_W'(wrap_dn);
    count_nxt = count_r;
    rem_nxt   = rem_r;
    pct_nxt   = pct_r;
    if (ok && is_alloc) begin
      count_nxt = count_r + 1'b1;
      rem_nxt   = rem_up[IW-1:0];
      pct_nxt   = pct_up;
    end else if (ok && item_r.op == OP_FREE) begin
      count_nxt = count_r - 1'b1;
      rem_nxt   = rem_dn[IW-1:0];
      pct_nxt   = pct_dn;
    end
  end

  always_comb begin
    count_x          = KW'(count_nxt);
    res.ok           = ok;
    res.handle       = is_alloc ? (ok ? pos_x[SLOT_W-1:0] : '0) : item_r.slot;
    res.peer_out     = '0;
    res.tag          = '0;
    res.used_count   = count_x[USED_W-1:0];
    res.used_percent = pct_nxt;
    if (ok) begin
      res.peer_out = is_alloc ? item_r.peer : peer_q;
      case (item_r.op)
        OP_ALLOC: res.tag = {new_tagh, {SEQ_W{1'b0}}};
        OP_FREE:  res.tag = {tagh_q, {SEQ_W{1'b0}}};
        OP_SEND:  res.tag = {tagh_q, send_q};
        OP_RECV:  res.tag = {tagh_q, recv_q};
        default:  res.tag = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      start_r     <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      pct_r       <= '0;
      own_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (cfg_valid) begin
        own_r <= cfg_data;
      end
      if (cmd.commit) begin
        count_r     <= count_nxt;
        rem_r       <= rem_nxt;
        pct_r       <= pct_nxt;
        out_valid_r <= 1'b1;
        if (ok && is_alloc) begin
          start_r <= pos_inc;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_r <= in_item;
    end
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before the beat was taken");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && ok && is_alloc) |=> (count_r == $past(count_r) + 1'b1))
    else $error("allocate did not bump the used count");

  a_pct_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(pct_r) * 32'(NUM_SLOTS) + 32'(rem_r) == 32'(count_r) * 32'(PERCENT)))
    else $error("usage percent out of step with used count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !full)
    else $error("scan running on a full table");

endmodule

// ===== rtl/virtual_channel_table.sv =====
// virtual channel table top level: slot allocator with tag and sequence tracking
//
//   channel | direction | handshake               | payload
//   in_     | input     | in_valid / in_ready     | in_item  (vct_in_t)
//   out_    | output    | out_valid / out_ready   | out_item (vct_out_t)
//   cfg_    | input     | cfg_valid / cfg_ready   | cfg_data (own node, 8 bits)
//
// free, send and receive pass through the read and check states from accept to result register
// allocate passes through read and check once more for every occupied slot probed, one ram read per probe
// after reset a clearing pass over all NUM_SLOTS slots zeroes the used bits, in_ready held low
// the result register lets the block accept a new beat while the last result waits
// a stalled output holds the block at its final step until the result beat is taken
module virtual_channel_table import vct_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vct_in_t           in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output vct_out_t          out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [NODE_W-1:0] cfg_data
);

  vct_cmd_t  cmd;
  vct_stat_t stat;

  assign cfg_ready = 1'b1;

  vct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vct_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== test/tb_virtual_channel_table.sv =====
// testbench for the virtual channel table: slot allocation, tags, sequence counts, usage
module tb_virtual_channel_table import vct_pkg::*;;

  class channel_book;
    bit                 busy      [NUM_SLOTS_DEF];
    logic [NODE_W-1:0]  partner   [NUM_SLOTS_DEF];
    logic [TAG_W-1:0]   chan_tag  [NUM_SLOTS_DEF];
    logic [SEQ_W-1:0]   tx_seq    [NUM_SLOTS_DEF];
    logic [SEQ_W-1:0]   rx_seq    [NUM_SLOTS_DEF];
    int unsigned        busy_total;
    int unsigned        scan_from;
    logic [NODE_W-1:0]  own_node;
    logic [SLOT_W-1:0]  live_handles [$];
    vct_out_t           pending_replies [$];
    int unsigned        err_count;

    function new();
      busy_total = 0;
      scan_from  = 0;
      own_node   = '0;
      err_count  = 0;
    endfunction

    // larger node, smaller node, kind, sequence nibble left clear
    function logic [TAG_W-1:0] channel_tag(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                           logic [KIND_W-1:0] kind);
      logic [NODE_W-1:0] hi;
      logic [NODE_W-1:0] lo;
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      return {hi, lo, kind, {SEQ_W{1'b0}}};
    endfunction

    task take_request(vct_in_t it);
      vct_out_t    reply;
      int unsigned pos;
      int          hits [$];
      reply = '0;
      if (it.op == OP_ALLOC) begin
        if (busy_total < NUM_SLOTS_DEF) begin
          pos = scan_from;
          while (busy[pos]) pos = (pos + 1) % NUM_SLOTS_DEF;
          busy[pos]     = 1'b1;
          partner[pos]  = it.peer;
          chan_tag[pos] = channel_tag(it.peer, own_node, it.chan_kind);
          tx_seq[pos]   = '0;
          rx_seq[pos]   = '0;
          busy_total++;
          scan_from = (pos + 1) % NUM_SLOTS_DEF;
          live_handles.push_back(SLOT_W'(pos));
          reply.ok       = 1'b1;
          reply.handle   = SLOT_W'(pos);
          reply.tag      = chan_tag[pos];
          reply.peer_out = it.peer;
        end
      end else begin
        reply.handle = it.slot;
        pos = 32'(it.slot);
        if (pos < NUM_SLOTS_DEF && busy[pos]) begin
          reply.ok       = 1'b1;
          reply.peer_out = partner[pos];
          case (it.op)
            OP_FREE: begin
              reply.tag = chan_tag[pos];
              busy[pos] = 1'b0;
              busy_total--;
              hits = live_handles.find_first_index(h) with (h == it.slot);
              live_handles.delete(hits[0]);
            end
            OP_SEND: begin
              reply.tag   = chan_tag[pos] | TAG_W'(tx_seq[pos]);
              tx_seq[pos] = tx_seq[pos] + 1'b1;
            end
            default: begin
              reply.tag   = chan_tag[pos] | TAG_W'(rx_seq[pos]);
              rx_seq[pos] = rx_seq[pos] + 1'b1;
            end
          endcase
        end
      end
      reply.used_count   = USED_W'(busy_total);
      reply.used_percent = PCT_W'((busy_total * PERCENT) / NUM_SLOTS_DEF);
      pending_replies.push_back(reply);
    endtask

    task report(string msg);
      err_count++;
      if (err_count <= 100) $display("mismatch: %s", msg);
    endtask

    task match_reply(vct_out_t got);
      vct_out_t want;
      if (pending_replies.size() == 0) begin
        report($sformatf("result beat %h with nothing pending", got));
        return;
      end
      want = pending_replies.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok got %0h want %0h", got.ok, want.ok));
      if (got.handle !== want.handle)
        report($sformatf("handle got %0h want %0h", got.handle, want.handle));
      if (got.tag !== want.tag)
        report($sformatf("tag got %0h want %0h (handle %0h)", got.tag, want.tag, want.handle));
      if (got.peer_out !== want.peer_out)
        report($sformatf("peer_out got %0h want %0h", got.peer_out, want.peer_out));
      if (got.used_count !== want.used_count)
        report($sformatf("used_count got %0d want %0d", got.used_count, want.used_count));
      if (got.used_percent !== want.used_percent)
        report($sformatf("used_percent got %0d want %0d", got.used_percent, want.used_percent));
    endtask
  endclass

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_PAD   = 64;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  vct_in_t           in_item   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  vct_out_t          out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [NODE_W-1:0] cfg_data  = '0;

  channel_book book;
  int unsigned cycles     = 0;
  int unsigned burst_left = 0;
  logic        hold_req   = 1'b0;
  logic        hold_ack   = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned rx_mode    = 0;
  int unsigned rx_left    = 0;

  virtual_channel_table #(.NUM_SLOTS(NUM_SLOTS_DEF)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               book.pending_replies.size());
      $display("tb_virtual_channel_table: errors");
      $finish;
    end
  end

  // result side: check every beat, stall in modes, and a long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.match_reply(out_item);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(20, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  function automatic vct_in_t mk(vct_op_t op, logic [NODE_W-1:0] peer,
                                 logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot);
    vct_in_t it;
    it.op        = op;
    it.peer      = peer;
    it.chan_kind = kind;
    it.slot      = slot;
    return it;
  endfunction

  // mostly live handles, oldest one hammered so its counters wrap; some random slots
  function automatic vct_in_t random_request(int unsigned cap);
    vct_in_t     it;
    int unsigned roll;
    it = mk(OP_ALLOC, NODE_W'($urandom_range(0, 255)), KIND_W'($urandom_range(0, 255)),
            SLOT_W'($urandom_range(0, 1023)));
    roll = $urandom_range(0, 99);
    if (book.live_handles.size() == 0 || (roll < 30 && book.busy_total < cap)) return it;
    if (roll < 50) it.op = OP_FREE;
    else if (roll < 75) it.op = OP_SEND;
    else it.op = OP_RECV;
    roll = $urandom_range(0, 99);
    if (roll < 40 && it.op != OP_FREE)
      it.slot = book.live_handles[0];
    else if (roll < 85)
      it.slot = book.live_handles[$urandom_range(0, book.live_handles.size() - 1)];
    return it;
  endfunction

  task automatic push_item(vct_in_t it);
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.take_request(it);
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (book.pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_own(logic [NODE_W-1:0] node);
    cfg_data  <= node;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    book.own_node = node;
  endtask

  task automatic run_random(int unsigned count, int unsigned cap);
    for (int unsigned n = 0; n < count; n++) begin
      pace();
      push_item(random_request(cap));
    end
  endtask

  initial begin
    logic [SLOT_W-1:0] h;
    book = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // own node 0: unused slots, first allocations, counters, free twice
    write_own(8'h00);
    push_item(mk(OP_SEND, 8'h00, 8'h00, 10'h000));
    push_item(mk(OP_RECV, 8'hff, 8'hff, 10'h3ff));
    push_item(mk(OP_FREE, 8'h00, 8'h00, 10'h005));
    push_item(mk(OP_ALLOC, 8'h00, 8'h00, 10'h000));
    push_item(mk(OP_ALLOC, 8'hff, 8'hff, 10'h3ff));
    push_item(mk(OP_SEND, 8'h00, 8'h00, 10'h000));
    push_item(mk(OP_SEND, 8'h00, 8'h00, 10'h000));
    push_item(mk(OP_RECV, 8'h00, 8'h00, 10'h000));
    push_item(mk(OP_RECV, 8'h00, 8'h00, 10'h001));
    push_item(mk(OP_SEND, 8'h00, 8'h00, 10'h001));
    push_item(mk(OP_FREE, 8'h00, 8'h00, 10'h000));
    push_item(mk(OP_FREE, 8'h00, 8'h00, 10'h000));
    push_item(mk(OP_SEND, 8'h00, 8'h00, 10'h000));
    // pointer has moved on, so this lands past the slot just freed
    push_item(mk(OP_ALLOC, 8'h5a, 8'ha5, 10'h000));

    settle();
    write_own(8'hff);
    push_item(mk(OP_ALLOC, 8'hff, 8'h01, 10'h000));
    push_item(mk(OP_ALLOC, 8'h00, 8'h80, 10'h000));
    push_item(mk(OP_SEND, 8'h00, 8'h00, 10'h003));
    push_item(mk(OP_RECV, 8'h00, 8'h00, 10'h004));
    push_item(mk(OP_FREE, 8'h00, 8'h00, 10'h001));
    push_item(mk(OP_FREE, 8'h00, 8'h00, 10'h002));

    // receiver holds off early in this phase so the block backs up
    settle();
    write_own(8'h80);
    hold_req <= ~hold_req;
    run_random(100, 48);

    settle();
    write_own(NODE_W'($urandom_range(0, 255)));
    run_random(60, 24);

    settle();
    write_own(8'h00);
    run_random(40, 48);

    // fill the whole table, pointer wraps around
    settle();
    write_own(8'h3c);
    while (book.busy_total < NUM_SLOTS_DEF) begin
      pace();
      push_item(mk(OP_ALLOC, NODE_W'($urandom_range(0, 255)),
                   KIND_W'($urandom_range(0, 255)), SLOT_W'($urandom_range(0, 1023))));
    end
    push_item(mk(OP_ALLOC, 8'h11, 8'h22, 10'h000));
    h = book.live_handles[$urandom_range(0, book.live_handles.size() - 1)];
    push_item(mk(OP_FREE, 8'h00, 8'h00, h));
    push_item(mk(OP_SEND, 8'h00, 8'h00, h));
    // one free slot somewhere: the scan walks the table until it reaches it
    push_item(mk(OP_ALLOC, 8'h3c, 8'hff, 10'h000));
    push_item(mk(OP_ALLOC, 8'h01, 8'h02, 10'h000));
    push_item(mk(OP_RECV, 8'h00, 8'h00, 10'h3ff));
    push_item(mk(OP_FREE, 8'h00, 8'h00, 10'h3ff));
    push_item(mk(OP_FREE, 8'h00, 8'h00, 10'h000));
    push_item(mk(OP_ALLOC, 8'hfe, 8'h7f, 10'h000));
    push_item(mk(OP_ALLOC, 8'h80, 8'h01, 10'h000));
    push_item(mk(OP_ALLOC, 8'h00, 8'h00, 10'h000));

    settle();
    repeat (DRAIN_PAD) @(posedge clk);
    if (book.err_count == 0)
      $display("tb_virtual_channel_table: clean");
    else
      $display("tb_virtual_channel_table: errors");
    $finish;
  end

endmodule
